// ===== src/cpf_pkg.sv =====
package cpf_pkg;

  localparam int COORD_BITS     = 11;
  localparam int DIST_BITS      = 2 * COORD_BITS + 1;
  localparam int MAX_POINTS_DEF = 256;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [DIST_BITS-1:0]  dist_t;

  // one stored point, y in the upper half
  typedef struct packed {
    coord_t y;
    coord_t x;
  } point_t;

  typedef struct packed {
    logic   last_point;
    coord_t point_y;
    coord_t point_x;
  } cpf_in_t;

  typedef struct packed {
    logic   overflowed;
    dist_t  min_dist_sq;
    coord_t second_y;
    coord_t second_x;
    coord_t first_y;
    coord_t first_x;
    logic   found;
  } cpf_out_t;

endpackage

// ===== src/cpf_ram.sv =====
module cpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/closest_pair_finder.sv =====
// closest_pair_finder: brute-force closest pair of 2-d points. A word is taken
// when start is high and busy is low; it carries one point and a last_point
// mark. The point is written to the point store and compared, one stored point
// per cycle, with every point that came before it in the set; point j > 0
// keeps the block busy for its j store reads and while the read data,
// difference, square and compare stages drain; the first point of a set
// needs no sweep. After the last point of a set both winners are read back
// from the store. The result word is shown for exactly
// one cycle with done_o high; the receiver cannot stall it, so it must take
// the word in that cycle. Ties keep the pair with the lower first index, then
// the lower second index. With fewer than two points found is 0 and the
// coordinates and distance read as 0. Points past MAX_POINTS are dropped and
// reported through overflowed. After a result the block is clear for a new
// set; the store needs no clearing after reset.
module closest_pair_finder #(
  parameter int MAX_POINTS = cpf_pkg::MAX_POINTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cpf_pkg::cpf_in_t  point_i,
  output logic              done_o,
  output cpf_pkg::cpf_out_t result_o
);

  import cpf_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SQ_W  = 2 * COORD_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_RD_A,
    S_RD_B,
    S_FIN
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   j_q;        // index of the point under comparison
  logic [IDX_W-1:0]   issue_q;    // next store entry to read
  point_t             cur_q;
  logic               last_q;
  logic               overflow_q;
  dist_t              best_dist_q;
  logic [IDX_W-1:0]   best_first_q;
  logic [IDX_W-1:0]   best_second_q;
  point_t             a_q;        // first point of the winning pair
  cpf_out_t           res_q;
  cpf_out_t           res_d;
  logic               done_q;

  // compare pipeline: read data -> differences -> squares -> compare
  logic               rv_q;
  logic [IDX_W-1:0]   ridx_q;
  logic               dv_q;
  logic [IDX_W-1:0]   didx_q;
  coord_t             dx_q;
  coord_t             dy_q;
  logic               sv_q;
  logic [IDX_W-1:0]   sidx_q;
  logic [SQ_W-1:0]    sqx_q;
  logic [SQ_W-1:0]    sqy_q;

  logic               accept;
  logic               full;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [IDX_W-1:0]   ram_raddr;
  point_t             ram_rdata;
  point_t             in_pt;
  dist_t              cand_dist;
  logic               take;
  logic               scan_end;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign full   = (count_q == CNT_W'(MAX_POINTS));

  assign in_pt.x = point_i.point_x;
  assign in_pt.y = point_i.point_y;

  // the new point goes into the store as soon as it is taken; the scan only
  // reads entries below it, so no read can meet this write
  assign ram_we    = accept && !full;
  assign ram_waddr = count_q[IDX_W-1:0];

  always_comb begin
    case (state_q)
      S_RD_A:  ram_raddr = best_first_q;
      S_RD_B:  ram_raddr = best_second_q;
      default: ram_raddr = issue_q;
    endcase
  end

  cpf_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_pt),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // candidate distance and replacement rule; the pair (0,1) always seeds
  assign cand_dist = DIST_BITS'(sqx_q) + DIST_BITS'(sqy_q);
  assign take = sv_q &&
                ((sidx_q == '0 && j_q == CNT_W'(1)) ||
                 (cand_dist < best_dist_q) ||
                 (cand_dist == best_dist_q && sidx_q < best_first_q));

  assign scan_end = ((CNT_W'(issue_q) + CNT_W'(1)) == j_q);

  // result word; in S_FIN read data holds the second point of the pair
  always_comb begin
    res_d            = '0;
    res_d.overflowed = overflow_q;
    if (count_q >= CNT_W'(2)) begin
      res_d.found       = 1'b1;
      res_d.first_x     = a_q.x;
      res_d.first_y     = a_q.y;
      res_d.second_x    = ram_rdata.x;
      res_d.second_y    = ram_rdata.y;
      res_d.min_dist_sq = best_dist_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
      dv_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      rv_q <= (state_q == S_SCAN);
      dv_q <= rv_q;
      sv_q <= dv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= issue_q;
    didx_q <= ridx_q;
    dx_q   <= (ram_rdata.x > cur_q.x) ? ram_rdata.x - cur_q.x : cur_q.x - ram_rdata.x;
    dy_q   <= (ram_rdata.y > cur_q.y) ? ram_rdata.y - cur_q.y : cur_q.y - ram_rdata.y;
    sidx_q <= didx_q;
    sqx_q  <= dx_q * dx_q;
    sqy_q  <= dy_q * dy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      j_q           <= '0;
      issue_q       <= '0;
      cur_q         <= '0;
      last_q        <= 1'b0;
      overflow_q    <= 1'b0;
      best_dist_q   <= '1;
      best_first_q  <= '0;
      best_second_q <= '0;
      a_q           <= '0;
      res_q         <= '0;
      done_q        <= 1'b0;
    end else begin
      done_q <= (state_q == S_FIN);

      if (take) begin
        best_dist_q   <= cand_dist;
        best_first_q  <= sidx_q;
        best_second_q <= j_q[IDX_W-1:0];
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cur_q  <= in_pt;
            last_q <= point_i.last_point;
            if (!full) begin
              j_q     <= count_q;
              count_q <= count_q + CNT_W'(1);
              issue_q <= '0;
              if (count_q != '0) begin
                state_q <= S_SCAN;
              end else if (point_i.last_point) begin
                state_q <= S_FIN;
              end
            end else begin
              // store full: point dropped, its mark still closes the set
              overflow_q <= 1'b1;
              if (point_i.last_point) begin
                state_q <= S_RD_A;
              end
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state_q <= S_DRAIN;
          end else begin
            issue_q <= issue_q + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          if (!rv_q && !dv_q && !sv_q) begin
            state_q <= last_q ? S_RD_A : S_IDLE;
          end
        end
        S_RD_A: begin
          state_q <= S_RD_B;
        end
        S_RD_B: begin
          a_q     <= ram_rdata;
          state_q <= S_FIN;
        end
        S_FIN: begin
          res_q         <= res_d;
          count_q       <= '0;
          best_dist_q   <= '1;
          best_first_q  <= '0;
          best_second_q <= '0;
          overflow_q    <= 1'b0;
          state_q       <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
